>>> rtl/core/pdsr_pkg.sv
// Shared types, constants and the microprogram of the PD speed regulator.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package pdsr_pkg;

    // Default sizing of the stored angle magnitude and timestamp
    localparam int PDSR_ANGLE_BITS = 16;
    localparam int PDSR_TIME_BITS  = 32;

    // Fixed field widths of the channels and the register port
    localparam int FIELD_ANGLE_W = 16;
    localparam int FIELD_TIME_W  = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;

    // PD term: signed, 20 fraction bits, clamped to [PD_LO, PD_HI]
    localparam int     PD_W    = 40;
    localparam int     PD_FRAC = 20;
    localparam longint PD_HI   = 64'sd1048576;        // 1.0
    localparam longint PD_LO   = -64'sd274877906944;  // -2^38, saturates speed anyway

    localparam int UC_PC_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_SPEED = 3'd0,
        CFG_TOP_SPEED     = 3'd1,
        CFG_PROP_GAIN     = 3'd2,
        CFG_DERIV_GAIN    = 3'd3,
        CFG_TURN_GAIN     = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_ENABLE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                            opcode;
        logic signed [FIELD_ANGLE_W-1:0] steer_angle;
        logic        [FIELD_TIME_W-1:0]  sample_time;
        logic                            button_pressed;
    } pdsr_in_t;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_rate;
        logic               stop_message;
    } pdsr_out_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] default_speed;
        logic signed [CFG_W-1:0] top_speed;
        logic signed [CFG_W-1:0] prop_gain;
        logic signed [CFG_W-1:0] deriv_gain;
        logic signed [CFG_W-1:0] turn_gain;
    } pdsr_cfg_t;

    // Shared multiplier operation; each one writes its own product register
    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_DERIV = 3'd1,
        MUL_PROP  = 3'd2,
        MUL_TURN  = 3'd3,
        MUL_SPEED = 3'd4
    } mul_op_t;

    typedef enum logic {
        JC_NONE     = 1'b0,
        JC_DIV_BUSY = 1'b1
    } jmp_cond_t;

    typedef logic [UC_PC_W-1:0] uc_pc_t;

    typedef struct packed {
        mul_op_t   mul_op;
        logic      div_start;
        logic      pd_load;
        jmp_cond_t jmp_cond;
        uc_pc_t    jmp_tgt;
        logic      last;
    } ctrl_t;

    // Microprogram addresses
    localparam uc_pc_t UC_DERIV = 3'd0;
    localparam uc_pc_t UC_PROP  = 3'd1;
    localparam uc_pc_t UC_WAIT  = 3'd2;
    localparam uc_pc_t UC_SUM   = 3'd3;
    localparam uc_pc_t UC_SPEED = 3'd4;
    localparam uc_pc_t UC_OUT   = 3'd5;

    localparam ctrl_t CTRL_NOP = '{
        mul_op:    MUL_NONE,
        div_start: 1'b0,
        pd_load:   1'b0,
        jmp_cond:  JC_NONE,
        jmp_tgt:   UC_DERIV,
        last:      1'b0
    };

    // Control store: one word per step
    function automatic ctrl_t uc_rom(input uc_pc_t pc);
        ctrl_t w;
        w = CTRL_NOP;
        case (pc)
            UC_DERIV: begin
                w.mul_op = MUL_DERIV;
            end
            UC_PROP: begin
                w.mul_op    = MUL_PROP;
                w.div_start = 1'b1;
            end
            UC_WAIT: begin
                w.mul_op   = MUL_TURN;
                w.jmp_cond = JC_DIV_BUSY;
                w.jmp_tgt  = UC_WAIT;
            end
            UC_SUM: begin
                w.pd_load = 1'b1;
            end
            UC_SPEED: begin
                w.mul_op = MUL_SPEED;
            end
            UC_OUT: begin
                w.last = 1'b1;
            end
            default: begin
                w = CTRL_NOP;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pd_speed_regulator_with_enable.sv
// PD speed regulator with autopilot enable: top level with handshakes,
// register file and sample state. Depends on pdsr_pkg, pdsr_seq, pdsr_dpath.
//
// Usage: an enable item (opcode 1) sets the autopilot from button_pressed and
// returns nothing. While enabled, each steering sample returns one speed/turn
// command, and no new item is taken until that command is in the output
// register. The longest part of each sample is the restoring divider of the
// derivative term: it retires one quotient bit per cycle over ANGLE_BITS + 16
// bits, in one of six microcode steps, and the output load follows the
// program. While disabled, the first sample after an enabled period returns
// one zero command with stop_message set, and later samples return nothing.
// The command sits in an output register, so the next item is taken while it
// waits for m_ready. Registers are to be written through cfg_we/cfg_index/
// cfg_wdata only while the block is idle; the block itself does not enforce
// this. Indexes past the last register are ignored. Only the low ANGLE_BITS
// bits of the angle and the low TIME_BITS bits of the timestamp are used.
`default_nettype none

module pd_speed_regulator_with_enable
    import pdsr_pkg::*;
#(
    parameter int ANGLE_BITS = PDSR_ANGLE_BITS,
    parameter int TIME_BITS  = PDSR_TIME_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pdsr_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pdsr_out_t                 m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    pdsr_cfg_t                cfg_reg;
    logic [ANGLE_BITS-1:0]    prev_abs_reg, prev_abs_next;
    logic [TIME_BITS-1:0]     prev_time_reg, prev_time_next;
    logic                     autopilot_reg, autopilot_next;
    logic                     stop_pending_reg, stop_pending_next;
    logic                     stop_res_reg, stop_res_next;
    logic                     m_valid_reg, m_valid_next;
    pdsr_out_t                m_data_reg;

    logic                     accept;
    logic                     out_load;
    logic                     run_start;
    logic [ANGLE_BITS-1:0]    angle_raw;
    logic signed [ANGLE_BITS-1:0] angle;
    logic [ANGLE_BITS-1:0]    mag;
    logic signed [ANGLE_BITS:0] diff;
    logic [TIME_BITS-1:0]     t_cur;
    logic [TIME_BITS-1:0]     dt;

    ctrl_t                    ctrl;
    logic                     seq_active;
    logic                     div_busy;
    logic signed [15:0]       lin_cmd;
    logic signed [15:0]       turn_cmd;

    // Narrow or widen the fixed-width fields to the configured sizes
    if (ANGLE_BITS <= FIELD_ANGLE_W) begin : g_angle_trunc
        assign angle_raw = s_data.steer_angle[ANGLE_BITS-1:0];
    end else begin : g_angle_ext
        assign angle_raw = {{(ANGLE_BITS - FIELD_ANGLE_W){1'b0}}, s_data.steer_angle};
    end

    if (TIME_BITS <= FIELD_TIME_W) begin : g_time_trunc
        assign t_cur = s_data.sample_time[TIME_BITS-1:0];
    end else begin : g_time_ext
        assign t_cur = {{(TIME_BITS - FIELD_TIME_W){1'b0}}, s_data.sample_time};
    end

    // Magnitude is kept unsigned, so the most negative angle stays exact
    assign angle = $signed(angle_raw);
    assign mag   = angle_raw[ANGLE_BITS-1] ? (~angle_raw + 1'b1) : angle_raw;
    assign diff  = $signed({1'b0, mag}) - $signed({1'b0, prev_abs_reg});
    assign dt    = t_cur - prev_time_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign run_start = accept && (s_data.opcode == OP_SAMPLE) && autopilot_reg;

    // Register file: plain writes, out-of-range indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEFAULT_SPEED: cfg_reg.default_speed <= cfg_wdata;
                CFG_TOP_SPEED:     cfg_reg.top_speed     <= cfg_wdata;
                CFG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_wdata;
                CFG_DERIV_GAIN:    cfg_reg.deriv_gain    <= cfg_wdata;
                CFG_TURN_GAIN:     cfg_reg.turn_gain     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Item dispatch and result hand-off
    always_comb begin
        state_next        = state_reg;
        prev_abs_next     = prev_abs_reg;
        prev_time_next    = prev_time_reg;
        autopilot_next    = autopilot_reg;
        stop_pending_next = stop_pending_reg;
        stop_res_next     = stop_res_reg;
        m_valid_next      = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == OP_ENABLE) begin
                        autopilot_next = s_data.button_pressed;
                    end else if (autopilot_reg) begin
                        // arm the stop command, save this sample, start the program
                        stop_pending_next = 1'b1;
                        stop_res_next     = 1'b0;
                        prev_abs_next     = mag;
                        prev_time_next    = t_cur;
                        state_next        = ST_RUN;
                    end else if (stop_pending_reg) begin
                        // one zero command after disable
                        stop_pending_next = 1'b0;
                        stop_res_next     = 1'b1;
                        state_next        = ST_EMIT;
                    end
                end
            end
            ST_RUN: begin
                if (ctrl.last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            prev_abs_reg     <= '0;
            prev_time_reg    <= '0;
            autopilot_reg    <= 1'b0;
            stop_pending_reg <= 1'b0;
            stop_res_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            prev_abs_reg     <= prev_abs_next;
            prev_time_reg    <= prev_time_next;
            autopilot_reg    <= autopilot_next;
            stop_pending_reg <= stop_pending_next;
            stop_res_reg     <= stop_res_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Output register: hold the command until taken
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (stop_res_reg) begin
                m_data_reg.linear_speed <= '0;
                m_data_reg.turn_rate    <= '0;
                m_data_reg.stop_message <= 1'b1;
            end else begin
                m_data_reg.linear_speed <= lin_cmd;
                m_data_reg.turn_rate    <= turn_cmd;
                m_data_reg.stop_message <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    pdsr_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (run_start),
        .div_busy (div_busy),
        .ctrl     (ctrl),
        .active   (seq_active)
    );

    pdsr_dpath #(
        .ANGLE_BITS (ANGLE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (run_start),
        .angle        (angle),
        .mag          (mag),
        .diff         (diff),
        .dt           (dt),
        .cfg          (cfg_reg),
        .ctrl         (ctrl),
        .div_busy     (div_busy),
        .linear_speed (lin_cmd),
        .turn_rate    (turn_cmd)
    );

    // The microprogram only runs while the top is in its compute state
    a_seq_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_active |-> (state_reg == ST_RUN))
        else $error("sequencer active outside compute state");

    // A new command only appears out of the emit state
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result valid raised outside emit state");

    // Emitting the zero command leaves nothing pending
    a_stop_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && stop_res_reg) |=> !stop_pending_reg)
        else $error("stop command emitted while another is still pending");

endmodule

`default_nettype wire

>>> rtl/core/pdsr_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pdsr_pkg for default sizing.
`default_nettype none

module pdsr_div
    import pdsr_pkg::*;
#(
    parameter int NUM_W = PDSR_ANGLE_BITS + 16,
    parameter int DEN_W = PDSR_TIME_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic      [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            rem_next  = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/pdsr_seq.sv
// Microcode sequencer: step counter, control store lookup, wait-on-divider jump.
// Depends on pdsr_pkg (ctrl_t, uc_rom).
`default_nettype none

module pdsr_seq
    import pdsr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire logic div_busy,
    output ctrl_t     ctrl,
    output logic      active
);

    uc_pc_t pc_reg, pc_next;
    logic   active_reg, active_next;
    ctrl_t  word;

    always_comb begin
        word        = uc_rom(pc_reg);
        ctrl        = active_reg ? word : CTRL_NOP;
        pc_next     = pc_reg;
        active_next = active_reg;
        if (start) begin
            pc_next     = UC_DERIV;
            active_next = 1'b1;
        end else if (active_reg) begin
            if (word.last) begin
                active_next = 1'b0;
            end
            if (word.jmp_cond == JC_DIV_BUSY && div_busy) begin
                pc_next = word.jmp_tgt;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= UC_DERIV;
            active_reg <= 1'b0;
        end else begin
            pc_reg     <= pc_next;
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

`default_nettype wire

>>> rtl/core/pdsr_dpath.sv
// Datapath: shared multiplier, derivative divider, PD clamp and output saturation.
// Depends on pdsr_pkg and pdsr_div; driven by the control word from pdsr_seq.
`default_nettype none

module pdsr_dpath
    import pdsr_pkg::*;
#(
    parameter int ANGLE_BITS = PDSR_ANGLE_BITS,
    parameter int TIME_BITS  = PDSR_TIME_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire logic signed [ANGLE_BITS-1:0] angle,
    input  wire logic        [ANGLE_BITS-1:0] mag,
    input  wire logic signed [ANGLE_BITS:0]   diff,
    input  wire logic        [TIME_BITS-1:0]  dt,
    input  wire pdsr_cfg_t                    cfg,
    input  wire ctrl_t                        ctrl,
    output logic                              div_busy,
    output logic signed [15:0]                linear_speed,
    output logic signed [15:0]                turn_rate
);

    localparam int NW = ANGLE_BITS + 16;
    localparam int MA = (ANGLE_BITS + 1 > PD_W) ? ANGLE_BITS + 1 : PD_W;
    localparam int SW = (ANGLE_BITS + 17 > PD_W) ? ANGLE_BITS + 17 : PD_W;
    localparam int SPD_W = PD_W + 17;
    localparam int LW = SPD_W - PD_FRAC + 1;

    logic signed [ANGLE_BITS-1:0] angle_reg;
    logic        [ANGLE_BITS-1:0] mag_reg;
    logic signed [ANGLE_BITS:0]   diff_reg;
    logic        [TIME_BITS-1:0]  dt_reg;
    logic signed [NW-1:0]         num_reg;
    logic signed [NW-1:0]         p_reg;
    logic signed [NW-1:0]         turn_reg;
    logic signed [PD_W-1:0]       pd_reg;
    logic signed [SPD_W-1:0]      spd_reg;
    logic signed [15:0]           lin_reg;
    logic signed [15:0]           ang_reg;

    logic signed [MA-1:0]         mul_a;
    logic signed [16:0]           mul_b;
    logic signed [MA+16:0]        prod;
    logic signed [16:0]           delta;
    logic        [NW-1:0]         num_u;
    logic        [NW-1:0]         num_mag;
    logic        [NW-1:0]         quo;
    logic signed [NW:0]           d_val;
    logic signed [SW-1:0]         pd_sum;
    logic signed [PD_W-1:0]       pd_clamp;
    logic signed [ANGLE_BITS+7:0] turn_sh;
    logic signed [SPD_W-PD_FRAC-1:0] spd_sh;
    logic signed [LW-1:0]         lin_sum;

    assign delta = 17'($signed(cfg.top_speed)) - 17'($signed(cfg.default_speed));

    // Operand select for the single shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_op)
            MUL_DERIV: begin
                mul_a = MA'(diff_reg);
                mul_b = 17'($signed(cfg.deriv_gain));
            end
            MUL_PROP: begin
                mul_a = MA'($signed({1'b0, mag_reg}));
                mul_b = 17'($signed(cfg.prop_gain));
            end
            MUL_TURN: begin
                mul_a = MA'(angle_reg);
                mul_b = 17'($signed(cfg.turn_gain));
            end
            MUL_SPEED: begin
                mul_a = MA'(pd_reg);
                mul_b = delta;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Derivative: divide magnitudes, truncate toward zero, restore sign.
    // A huge tick count gives a zero quotient by itself; a zero count forces zero.
    always_comb begin
        num_u   = num_reg;
        num_mag = num_reg[NW-1] ? (~num_u + 1'b1) : num_u;
        if (dt_reg == '0) begin
            d_val = '0;
        end else if (num_reg[NW-1]) begin
            d_val = -$signed({1'b0, quo});
        end else begin
            d_val = $signed({1'b0, quo});
        end
        pd_sum = SW'(p_reg) + SW'(d_val);
        if (pd_sum >= SW'(PD_HI)) begin
            pd_clamp = PD_W'(PD_HI);
        end else if (pd_sum < SW'(PD_LO)) begin
            pd_clamp = PD_W'(PD_LO);
        end else begin
            pd_clamp = PD_W'(pd_sum);
        end
    end

    // Floor shifts back to Q16.0, the scale of the angle and speed registers
    assign turn_sh = $signed(turn_reg[NW-1:8]);
    assign spd_sh  = $signed(spd_reg[SPD_W-1:PD_FRAC]);
    assign lin_sum = LW'(spd_sh) + LW'($signed(cfg.default_speed));

    pdsr_div #(
        .NUM_W (NW),
        .DEN_W (TIME_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .num     (num_mag),
        .den     (dt_reg),
        .busy    (div_busy),
        .quo     (quo)
    );

    always_ff @(posedge aclk) begin
        if (load) begin
            angle_reg <= angle;
            mag_reg   <= mag;
            diff_reg  <= diff;
            dt_reg    <= dt;
        end
        case (ctrl.mul_op)
            MUL_DERIV: num_reg  <= $signed(prod[NW-1:0]);
            MUL_PROP:  p_reg    <= $signed(prod[NW-1:0]);
            MUL_TURN:  turn_reg <= $signed(prod[NW-1:0]);
            MUL_SPEED: spd_reg  <= $signed(prod[SPD_W-1:0]);
            default: begin
            end
        endcase
        if (ctrl.pd_load) begin
            pd_reg <= pd_clamp;
        end
        if (ctrl.last) begin
            lin_reg <= sat16(64'(lin_sum));
            ang_reg <= sat16(64'(turn_sh));
        end
    end

    assign linear_speed = lin_reg;
    assign turn_rate    = ang_reg;

endmodule

`default_nettype wire

>>> dv/pd_speed_regulator_with_enable_tb.sv
// Self-checking testbench for pd_speed_regulator_with_enable: a directed table,
// then random steering and enable items over several register settings.
// Depends on pdsr_pkg and the RTL under rtl/core; reads no files.
`default_nettype none

module pd_speed_regulator_with_enable_tb;
    import pdsr_pkg::*;

    // Run shape
    localparam int CFG_NUM_REGS  = 5;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int PHASES        = 12;
    localparam int PER_PHASE     = RANDOM_ITEMS / PHASES;
    localparam int SETTLE_CYCLES = PDSR_ANGLE_BITS + 24 + 8;  // one sample plus margin
    localparam int DRAIN_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 30;

    // Fixed-point constants of the command arithmetic
    localparam int     GAIN_FRAC = 8;
    localparam longint ONE_Q20   = 64'sd1 <<< PD_FRAC;
    localparam longint PD_FLOOR  = -(64'sd1 <<< 44);

    localparam pdsr_out_t NO_CMD      = '0;
    localparam pdsr_out_t ZERO_MOTION = '{16'sd0, 16'sd0, 1'b0};
    localparam pdsr_out_t STOP_CMD    = '{16'sd0, 16'sd0, 1'b1};

    // How a stimulus row is checked, or whether it writes the registers instead
    typedef enum logic [1:0] {
        ROW_PREDICT,  // expected command comes from the predictor
        ROW_QUIET,    // no command may follow this item
        ROW_EXACT,    // expected command is typed into the row
        ROW_CONFIG    // wait for idle, then write the register set
    } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        pdsr_in_t   item;
        pdsr_out_t  want;
        pdsr_cfg_t  regs;
    } stim_row_t;

    // DUT signals; every input is known from time zero
    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    pdsr_in_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    pdsr_out_t m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Sideband that travels with s_data: how the scoreboard treats the item
    row_kind_t row_tag  = ROW_PREDICT;
    pdsr_out_t row_want = '0;

    // Predictor state: register copy and the regulator's own memory
    pdsr_cfg_t                  regs       = '0;
    logic [PDSR_ANGLE_BITS-1:0] last_mag   = '0;
    logic [PDSR_TIME_BITS-1:0]  last_stamp = '0;
    bit                         pilot_on   = 1'b0;
    bit                         stop_owed  = 1'b0;

    pdsr_out_t   pending_cmds[$];
    int          mismatches    = 0;
    int unsigned cycles        = 0;
    int          send_idle_pct = 20;
    int          recv_idle_pct = 52;
    logic [PDSR_TIME_BITS-1:0] tick = '0;  // timestamp of the random stream
    stim_row_t   directed[$];

    pd_speed_regulator_with_enable uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: drop ready at random, at the rate of the current phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic flag(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch @%0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Speed/turn predictor. Returns 1 when the item yields a command.
    function automatic bit regulate(input pdsr_in_t it, output pdsr_out_t cmd);
        longint angle, mag, p, d, pd, delta;
        logic [PDSR_TIME_BITS-1:0] dt;
        cmd = NO_CMD;
        if (it.opcode == OP_ENABLE) begin
            pilot_on = it.button_pressed;
            return 1'b0;
        end
        // Disabled: one stop command after an enabled stretch, then silence
        if (!pilot_on) begin
            if (!stop_owed) begin
                return 1'b0;
            end
            stop_owed = 1'b0;
            cmd = STOP_CMD;
            return 1'b1;
        end
        stop_owed = 1'b1;
        angle = $signed(it.steer_angle);
        mag   = (angle < 0) ? -angle : angle;
        dt    = it.sample_time - last_stamp;  // wraps with the timestamp width
        p     = regs.prop_gain * mag;
        // Derivative truncates toward zero; a zero interval contributes nothing
        d = 0;
        if (dt != 0) begin
            d = (regs.deriv_gain * (mag - longint'(last_mag))) / longint'(dt);
        end
        last_mag   = mag[PDSR_ANGLE_BITS-1:0];
        last_stamp = it.sample_time;
        pd = p + d;
        if (pd > ONE_Q20) begin
            pd = ONE_Q20;
        end
        if (pd < PD_FLOOR) begin
            pd = PD_FLOOR;
        end
        delta = regs.top_speed - regs.default_speed;
        cmd.linear_speed = clip16(regs.default_speed + ((pd * delta) >>> PD_FRAC));
        cmd.turn_rate    = clip16((regs.turn_gain * angle) >>> GAIN_FRAC);
        cmd.stop_message = 1'b0;
        return 1'b1;
    endfunction

    // Scoreboard: check the result first, then predict the newly taken item,
    // so a same-edge result can never consume its own expectation.
    always @(posedge aclk) begin : scoreboard
        pdsr_out_t cmd, want;
        bit        fired;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_cmds.size() == 0) begin
                    flag($sformatf("command %0d/%0d/%0d with none expected",
                        m_data.linear_speed, m_data.turn_rate, m_data.stop_message));
                end else begin
                    want = pending_cmds.pop_front();
                    if (m_data.linear_speed !== want.linear_speed) begin
                        flag($sformatf("linear_speed %0d, expected %0d",
                            m_data.linear_speed, want.linear_speed));
                    end
                    if (m_data.turn_rate !== want.turn_rate) begin
                        flag($sformatf("turn_rate %0d, expected %0d",
                            m_data.turn_rate, want.turn_rate));
                    end
                    if (m_data.stop_message !== want.stop_message) begin
                        flag($sformatf("stop_message %0b, expected %0b",
                            m_data.stop_message, want.stop_message));
                    end
                end
            end
            if (s_valid && s_ready) begin
                fired = regulate(s_data, cmd);
                case (row_tag)
                    ROW_EXACT: begin
                        pending_cmds.push_back(row_want);
                    end
                    ROW_QUIET: begin
                    end
                    default: begin
                        if (fired) begin
                            pending_cmds.push_back(cmd);
                        end
                    end
                endcase
            end
        end
    end

    // Offer one item: idle first at the sender rate, then hold valid until taken
    task automatic send_item(input pdsr_in_t it, input row_kind_t kind,
                             input pdsr_out_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_data   <= it;
        row_tag  <= kind;
        row_want <= want;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Drop valid, wait for every command, then let a last sample finish
    task automatic wait_idle();
        int spin;
        spin = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_cmds.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge aclk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic poke(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Write all registers back to back, plus one write past the last index
    task automatic apply_regs(input pdsr_cfg_t c);
        wait_idle();
        poke(CFG_DEFAULT_SPEED, c.default_speed);
        poke(CFG_TOP_SPEED,     c.top_speed);
        poke(CFG_PROP_GAIN,     c.prop_gain);
        poke(CFG_DERIV_GAIN,    c.deriv_gain);
        poke(CFG_TURN_GAIN,     c.turn_gain);
        poke(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_NUM_REGS)),
             CFG_W'($urandom));
        cfg_we <= 1'b0;
        regs = c;
    endtask

    function automatic stim_row_t make_row(input row_kind_t k, input opcode_t op,
                                           input logic [15:0] ang, input logic [31:0] t,
                                           input logic btn, input pdsr_out_t want);
        stim_row_t r;
        r.kind = k;
        r.item = '{opcode: op, steer_angle: ang, sample_time: t, button_pressed: btn};
        r.want = want;
        r.regs = '0;
        return r;
    endfunction

    function automatic stim_row_t regs_row(input pdsr_cfg_t c);
        stim_row_t r;
        r      = make_row(ROW_CONFIG, OP_SAMPLE, '0, '0, 1'b0, NO_CMD);
        r.regs = c;
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg();
        int v;
        case ($urandom_range(5))
            0: v = 32767;
            1: v = -32768;
            2: v = 0;
            3: v = $urandom;
            default: v = int'($urandom_range(4096)) - 2048;
        endcase
        return v[CFG_W-1:0];
    endfunction

    // Mostly enabled samples on a steadily advancing clock; now and then an
    // enable change, a repeated stamp, a jump or a run up to the wrap point.
    function automatic pdsr_in_t next_item();
        pdsr_in_t it;
        int       a;
        it = '0;
        if ($urandom_range(99) < 6) begin
            it.opcode         = OP_ENABLE;
            it.button_pressed = ($urandom_range(3) != 0);
            it.steer_angle    = FIELD_ANGLE_W'($urandom);
            it.sample_time    = $urandom;
            return it;
        end
        it.opcode         = OP_SAMPLE;
        it.button_pressed = 1'($urandom_range(1));
        case ($urandom_range(19))
            0: begin
            end
            1: tick = $urandom;
            2: tick = 32'hFFFF_FFFF - $urandom_range(40);
            default: tick = tick + $urandom_range(64, 1);
        endcase
        it.sample_time = tick;
        case ($urandom_range(9))
            0: a = -32768;
            1: a = 32767;
            2: a = 0;
            3, 4: a = $urandom;
            default: a = int'($urandom_range(4096)) - 2048;
        endcase
        it.steer_angle = a[15:0];
        return it;
    endfunction

    initial begin : stimulus
        pdsr_cfg_t c;
        int        phase, n, i;

        // Directed table. Zero registers first: commands are exact by inspection.
        directed.push_back(make_row(ROW_QUIET, OP_SAMPLE, 16'h7FFF, 32'd100, 1'b1, NO_CMD));
        directed.push_back(make_row(ROW_QUIET, OP_ENABLE, 16'h0000, 32'd0, 1'b1, NO_CMD));
        directed.push_back(make_row(ROW_EXACT, OP_SAMPLE, 16'h8000, 32'hFFFF_FFFF, 1'b0,
                                    ZERO_MOTION));
        directed.push_back(make_row(ROW_QUIET, OP_ENABLE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0,
                                    NO_CMD));
        directed.push_back(make_row(ROW_EXACT, OP_SAMPLE, 16'h1234, 32'd7, 1'b1, STOP_CMD));
        directed.push_back(make_row(ROW_QUIET, OP_SAMPLE, 16'h4321, 32'd9, 1'b1, NO_CMD));
        directed.push_back(make_row(ROW_QUIET, OP_ENABLE, 16'h0000, 32'd0, 1'b1, NO_CMD));
        // Moderate gains: half angle, repeated stamp, clamp at 1.0, wrap, most negative
        directed.push_back(regs_row('{16'sh1000, 16'sh3000, 16'sh0100, 16'sh0080, 16'sh0200}));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h0800, 32'd1000, 1'b0, NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h0C00, 32'd1000, 1'b0, NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h7FFF, 32'd1010, 1'b0, NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'hF000, 32'hFFFF_FFF0, 1'b0,
                                    NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h2000, 32'h0000_0010, 1'b0,
                                    NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h8000, 32'h0000_0011, 1'b0,
                                    NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h0000, 32'h0000_0012, 1'b0,
                                    NO_CMD));
        // Extreme registers: large negative PD, saturated outputs both ways
        directed.push_back(regs_row('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF}));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h8000, 32'd500, 1'b0, NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h7FFF, 32'd501, 1'b0, NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'h0000, 32'd502, 1'b0, NO_CMD));
        // Disable: one stop command, then silence; state must survive it
        directed.push_back(make_row(ROW_QUIET, OP_ENABLE, 16'h7FFF, 32'hFFFF_FFFF, 1'b0,
                                    NO_CMD));
        directed.push_back(make_row(ROW_EXACT, OP_SAMPLE, 16'h7FFF, 32'd9000, 1'b1, STOP_CMD));
        directed.push_back(make_row(ROW_QUIET, OP_SAMPLE, 16'h8000, 32'd9500, 1'b1, NO_CMD));
        directed.push_back(make_row(ROW_QUIET, OP_ENABLE, 16'h0000, 32'd0, 1'b1, NO_CMD));
        directed.push_back(make_row(ROW_PREDICT, OP_SAMPLE, 16'hFFFF, 32'd503, 1'b0, NO_CMD));

        // Hold reset, then release it once
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < directed.size(); i++) begin
            if (directed[i].kind == ROW_CONFIG) begin
                apply_regs(directed[i].regs);
            end else begin
                send_item(directed[i].item, directed[i].kind, directed[i].want);
            end
        end

        // Random phases: new registers each phase; idle rates swap, then stop
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: c = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
                1: c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
                2: c = '{16'sh1000, 16'sh4000, 16'sh0100, 16'sh0400, 16'sh0100};
                default: c = '{pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg()};
            endcase
            apply_regs(c);
            if (phase < PHASES / 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 52;
            end else if (phase < 2 * PHASES / 3) begin
                send_idle_pct = 52;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (n = 0; n < PER_PHASE; n++) begin
                send_item(next_item(), ROW_PREDICT, NO_CMD);
            end
        end

        wait_idle();
        if (pending_cmds.size() != 0) begin
            flag($sformatf("%0d expected commands never arrived", pending_cmds.size()));
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/pdsr_pkg.sv
rtl/core/pdsr_div.sv
rtl/core/pdsr_seq.sv
rtl/core/pdsr_dpath.sv
rtl/core/pd_speed_regulator_with_enable.sv
dv/pd_speed_regulator_with_enable_tb.sv
